// ----- design/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the commuting swap cancellation core: the
// controller states, the command and status groups between controller and
// datapath, the fixed field widths and the default stack depth.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int NODE_W          = 16;
	localparam int COUNT_W         = 16;
	localparam int EDGE_W          = 2 * NODE_W;
	localparam int STACK_DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_SCAN,
		S_SHIFT,
		S_AFTER,
		S_OUT_LOAD,
		S_OUT_WAIT
	} state_t;

	// Source of the stack read address.
	typedef enum logic [2:0] {
		RA_TOP,
		RA_DEC,
		RA_INC1,
		RA_INC2,
		RA_ZERO
	} rd_sel_t;

	// Update of the scan pointer.
	typedef enum logic [2:0] {
		P_HOLD,
		P_TOP,
		P_DEC,
		P_INC,
		P_ZERO
	} ptr_op_t;

	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		rd_sel_t rd_sel;
		ptr_op_t ptr_op;
		logic    push;
		logic    wr_shift;
		logic    count_dec;
		logic    bump_removed;
		logic    out_load;
		logic    out_empty;
		logic    clear_all;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic ptr_zero;
		logic is_top;
		logic shift_more;
		logic eq;
		logic touch;
		logic last_item;
		logic run_last;
	} status_t;

endpackage

// ----- design/csc_ctrl.sv -----
// ----------------------------------------------------------------------------
// csc_ctrl
// Controller state machine: sequences the stack scan, the close-up shift,
// the push and the readout of the reduced path.
// ----------------------------------------------------------------------------
module csc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  csc_pkg::status_t sts,
	output csc_pkg::cmd_t    cmd
);
	import csc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RA_TOP;
					cmd.ptr_op    = P_TOP;
					state_d       = sts.count_zero ? S_PUSH : S_SCAN;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_AFTER;
			end
			S_SCAN: begin
				if (sts.eq) begin
					cmd.bump_removed = 1'b1;
					if (sts.is_top) begin
						cmd.count_dec = 1'b1;
						state_d       = S_AFTER;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_INC1;
						state_d    = S_SHIFT;
					end
				end else if (sts.touch || sts.ptr_zero) begin
					cmd.push = 1'b1;
					state_d  = S_AFTER;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_DEC;
					cmd.ptr_op = P_DEC;
				end
			end
			S_SHIFT: begin
				cmd.wr_shift = 1'b1;
				if (sts.shift_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_INC2;
					cmd.ptr_op = P_INC;
				end else begin
					cmd.count_dec = 1'b1;
					state_d       = S_AFTER;
				end
			end
			S_AFTER: begin
				if (!sts.last_item) begin
					state_d = S_IDLE;
				end else if (sts.count_zero) begin
					cmd.out_load  = 1'b1;
					cmd.out_empty = 1'b1;
					state_d       = S_OUT_WAIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_ZERO;
					cmd.ptr_op = P_ZERO;
					state_d    = S_OUT_LOAD;
				end
			end
			S_OUT_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.run_last) begin
						cmd.clear_all = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_INC1;
						cmd.ptr_op = P_INC;
						state_d    = S_OUT_LOAD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/csc_dp.sv -----
// ----------------------------------------------------------------------------
// csc_dp
// Datapath: step stack memory, scan pointer, stack count, removed count,
// overflow flag, edge comparators and the result register.
// ----------------------------------------------------------------------------
module csc_dp #(
	parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [csc_pkg::NODE_W-1:0]   node_u,
	input  logic [csc_pkg::NODE_W-1:0]   node_v,
	input  logic                         path_end,
	output logic [csc_pkg::NODE_W-1:0]   step_u,
	output logic [csc_pkg::NODE_W-1:0]   step_v,
	output logic                         list_empty,
	output logic                         overflow,
	output logic [csc_pkg::COUNT_W-1:0]  removed_total,
	output logic                         run_last,
	input  csc_pkg::cmd_t                cmd,
	output csc_pkg::status_t             sts
);
	import csc_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [EDGE_W-1:0]  mem [STACK_DEPTH];
	logic [EDGE_W-1:0]  rdata_q;
	logic [NODE_W-1:0]  edge_u_q;
	logic [NODE_W-1:0]  edge_v_q;
	logic               last_q;
	logic [AW-1:0]      ptr_q;
	logic [CW-1:0]      count_q;
	logic [COUNT_W-1:0] removed_q;
	logic               overflow_q;

	logic [CW-1:0]      count_m1;
	logic [CW:0]        ptr_p1;
	logic [CW:0]        ptr_p2;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [EDGE_W-1:0]  wr_data;
	logic               wr_en;
	logic               full;
	logic [NODE_W-1:0]  e_u;
	logic [NODE_W-1:0]  e_v;

	assign count_m1 = count_q - 1'b1;
	assign ptr_p1   = (CW + 1)'(ptr_q) + 1'b1;
	assign ptr_p2   = (CW + 1)'(ptr_q) + 2'd2;
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign e_u      = rdata_q[EDGE_W-1:NODE_W];
	assign e_v      = rdata_q[NODE_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RA_TOP:  rd_addr = count_m1[AW-1:0];
			RA_DEC:  rd_addr = ptr_q - 1'b1;
			RA_INC1: rd_addr = ptr_p1[AW-1:0];
			RA_INC2: rd_addr = ptr_p2[AW-1:0];
			RA_ZERO: rd_addr = '0;
			default: rd_addr = '0;
		endcase
	end

	// A push writes the new step at the top unless the stack is full; a shift
	// moves the entry just read down one slot to close the gap.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = rdata_q;
		if (cmd.push && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = {edge_u_q, edge_v_q};
		end else if (cmd.wr_shift) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			edge_u_q <= node_u;
			edge_v_q <= node_v;
		end
		if (cmd.out_load) begin
			step_u        <= cmd.out_empty ? '0 : e_u;
			step_v        <= cmd.out_empty ? '0 : e_v;
			list_empty    <= cmd.out_empty;
			overflow      <= overflow_q;
			removed_total <= removed_q;
			run_last      <= cmd.out_empty || (ptr_p1 == (CW + 1)'(count_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= 1'b0;
			ptr_q      <= '0;
			count_q    <= '0;
			removed_q  <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				last_q <= path_end;
			end
			case (cmd.ptr_op)
				P_HOLD:  ptr_q <= ptr_q;
				P_TOP:   ptr_q <= count_m1[AW-1:0];
				P_DEC:   ptr_q <= ptr_q - 1'b1;
				P_INC:   ptr_q <= ptr_p1[AW-1:0];
				P_ZERO:  ptr_q <= '0;
				default: ptr_q <= ptr_q;
			endcase
			if (cmd.clear_all) begin
				count_q    <= '0;
				removed_q  <= '0;
				overflow_q <= 1'b0;
			end else begin
				if (cmd.push) begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end else if (cmd.count_dec) begin
					count_q <= count_m1;
				end
				if (cmd.bump_removed) begin
					if (removed_q >= {{(COUNT_W - 1){1'b1}}, 1'b0}) begin
						removed_q <= '1;
					end else begin
						removed_q <= removed_q + 2'd2;
					end
				end
			end
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.ptr_zero   = (ptr_q == '0);
	assign sts.is_top     = (ptr_p1 == (CW + 1)'(count_q));
	assign sts.shift_more = (ptr_p2 < (CW + 1)'(count_q));
	assign sts.eq         = ((e_u == edge_u_q) && (e_v == edge_v_q))
	                     || ((e_u == edge_v_q) && (e_v == edge_u_q));
	assign sts.touch      = (e_u == edge_u_q) || (e_u == edge_v_q)
	                     || (e_v == edge_u_q) || (e_v == edge_v_q);
	assign sts.last_item  = last_q;
	assign sts.run_last   = run_last;

endmodule

// ----- design/commuting_swap_cancellation_core.sv -----
// An item with an empty stack is pushed directly. The longest item is one that cancels the
// bottom entry of a full stack and closes the gap; a full scan that ends in a push is shorter.
// Throughput: one item at a time; a new item is taken only when the controller is idle again
// after the scan, the shift and any push over the stack memory.
// Readout after a path end item gives one result at a time, each held until out_ready takes it.
// Reset: arst_n clears the counts, overflow flag and controller; the stack memory is not.
// ----------------------------------------------------------------------------
// commuting_swap_cancellation_core
// Reduces a path of swap steps by cancelling a step against an earlier
// identical edge that commutes with everything in between, and reads out
// the surviving steps on the item marked as path end.
// ----------------------------------------------------------------------------
module commuting_swap_cancellation_core #(
	parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [csc_pkg::NODE_W-1:0]   node_u,
	input  logic [csc_pkg::NODE_W-1:0]   node_v,
	input  logic                         path_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [csc_pkg::NODE_W-1:0]   step_u,
	output logic [csc_pkg::NODE_W-1:0]   step_v,
	output logic                         list_empty,
	output logic                         overflow,
	output logic [csc_pkg::COUNT_W-1:0]  removed_total,
	output logic                         run_last
);
	import csc_pkg::*;

	// The controller owns sequencing only. Every stored value (the stack
	// memory, the scan pointer, counts and the result register) lives in the
	// datapath, and the two talk through one command and one status group.
	// No entry above the stack count is ever used, so the memory needs no
	// clearing after reset.
	cmd_t    cmd;
	status_t sts;

	// An accepted beat is latched, then the stack is scanned from the top
	// one entry per cycle using a registered memory read. A matching edge
	// erases its entry and the entries above it are moved down one slot per
	// cycle; a touching edge or the bottom of the stack ends the scan with
	// a push, or with the overflow flag when the stack is full.
	csc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// On a path end beat the surviving steps are read out bottom first
	// through the result register, which holds each beat until it is taken.
	// Taking the final beat clears the counts for the next path.
	csc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.node_u        (node_u),
		.node_v        (node_v),
		.path_end      (path_end),
		.step_u        (step_u),
		.step_v        (step_v),
		.list_empty    (list_empty),
		.overflow      (overflow),
		.removed_total (removed_total),
		.run_last      (run_last),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
